@@ src/lphm_pkg.sv @@
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared codes and types for the linear probing hash map unit: operation and
// status codes, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam logic [2:0] OP_FIND   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DNE = 2'd1;
  localparam logic [1:0] STAT_AE  = 2'd2;
  localparam logic [1:0] STAT_OOM = 2'd3;

  localparam logic CFG_GROW   = 1'b0;
  localparam logic CFG_SHRINK = 1'b1;

  localparam int          LOAD_BITS    = 10;
  localparam logic [9:0]  GROW_RESET   = 10'd768;
  localparam logic [9:0]  SHRINK_RESET = 10'd256;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_PSTART,
    S_PMOD,
    S_PRD,
    S_PCHK,
    S_ERD,
    S_ECHK,
    S_EMOD,
    S_ECMP,
    S_EEND,
    S_RCALC,
    S_RDEC,
    S_RCLR,
    S_HRD,
    S_HCHK,
    S_HMOD,
    S_HPRD,
    S_HPCHK,
    S_DONE
  } lphm_state_t;

endpackage

@@ src/lphm_mod.sv @@
// ----------------------------------------------------------------------------
// lphm_mod
// Shared remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lphm_mod #(
  parameter int DW = 32,
  parameter int SW = 11,
  parameter int RW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] div_r;
  logic [SW:0]   trial;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = SW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = SW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = RW'(rem_r);

endmodule

@@ src/linear_probe_hash_map_unit.sv @@
// An item finds its home slot through the shared remainder unit, then probes
// the slots that follow; an erase passes each later member of the cluster
// through the remainder unit as well. A resize clears the new table and
// rehashes every live entry through the same remainder unit. After reset and
// on each clear operation the slot memory is swept, one entry a cycle, over
// all 2 * 2**clog2(CAPACITY) entries of both banks, during which no
// transaction is accepted.
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// Open addressing key/value map with linear probing, backward shift erase and
// load driven grow and shrink between two banks of slot memory.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_unit #(
  parameter int CAPACITY       = 1024,
  parameter int MIN_TABLE_SIZE = 29,
  parameter int KEY_BITS       = 32,
  parameter int VALUE_BITS     = 32,
  parameter int HASH_BITS      = 32,
  localparam int SW    = $clog2(CAPACITY + 1),
  localparam int IN_W  = ((3 + KEY_BITS + HASH_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 + VALUE_BITS + SW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op, key, key_hash, value, zero fill
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status, found_value, entries, zero fill
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [lphm_pkg::LOAD_BITS-1:0] cfg_wdata
);

  import lphm_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int AW = IW + 1;
  localparam int PW = SW + LOAD_BITS;
  localparam int K0 = 3;
  localparam int H0 = K0 + KEY_BITS;
  localparam int V0 = H0 + HASH_BITS;

  typedef struct packed {
    logic                  used;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [HASH_BITS-1:0]  hash;
  } slot_t;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] x, input logic [SW-1:0] n);
    logic [SW-1:0] y;
    y = SW'(x) + SW'(1);
    inc = (y == n) ? '0 : IW'(y);
  endfunction

  slot_t mem [2**AW];

  lphm_state_t state_r, state_nxt;

  logic [2:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HASH_BITS-1:0]  hash_r, hash_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic                  bank_r, bank_nxt;
  logic [LOAD_BITS-1:0]  grow_r, shrink_r;
  logic [SW-1:0]         ns_r, ns_nxt;
  logic [IW-1:0]         p_r, p_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         hole_r, hole_nxt;
  logic [SW-1:0]         k_r, k_nxt;
  slot_t                 ent_r, ent_nxt;
  slot_t                 rd_r;
  logic [AW-1:0]         sweep_r, sweep_nxt;
  logic                  clr_res_r, clr_res_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0] res_found_r, res_found_nxt;
  logic [PW-1:0]         gthr_r, sthr_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [VALUE_BITS-1:0] out_found_r;
  logic [SW-1:0]         out_entries_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic                 mod_start;
  logic [HASH_BITS-1:0] mod_dvd;
  logic [SW-1:0]        mod_dvs;
  logic                 mod_done;
  logic [IW-1:0]        mod_rem;

  logic [PW-1:0] n_w, gthr_c, sthr_c;
  logic [SW+1:0] ns_grow;
  logic [SW-1:0] ns_shr;
  logic          is_store, rd_match, k_last, kh_last, i_last, ns_last;
  logic          grow, grow_fail, shrink_ok, keep;
  logic [IW-1:0] p_inc, i_inc, ph_inc;

  lphm_mod #(.DW(HASH_BITS), .SW(SW), .RW(IW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Load thresholds: the size's whole-1024 part, plus its fraction for grow.
  always_comb begin
    n_w    = PW'(size_r);
    gthr_c = (n_w >> LOAD_BITS) * PW'(grow_r)
           + (((n_w & PW'(1023)) * PW'(grow_r)) >> LOAD_BITS);
    sthr_c = (n_w >> LOAD_BITS) * PW'(shrink_r);
  end

  always_comb begin
    is_store  = (op_r == OP_INSERT) || (op_r == OP_UPDATE);
    rd_match  = rd_r.used && (rd_r.hash == hash_r) && (rd_r.key == key_r);
    k_last    = (k_r == size_r - SW'(1));
    kh_last   = (k_r == ns_r - SW'(1));
    i_last    = (SW'(i_r) == size_r - SW'(1));
    ns_last   = (SW'(i_r) == ns_r - SW'(1));
    p_inc     = inc(p_r, size_r);
    i_inc     = inc(i_r, size_r);
    ph_inc    = inc(p_r, ns_r);
    ns_grow   = {1'b0, size_r, 1'b0} + (SW+2)'(3);
    ns_shr    = (size_r - SW'(3)) >> 1;
    grow      = (PW'(cnt_r) >= gthr_r);
    grow_fail = (ns_grow > (SW+2)'(CAPACITY));
    shrink_ok = (PW'(cnt_r) < sthr_r) && (size_r != SW'(MIN_TABLE_SIZE))
             && (size_r >= SW'(3)) && (ns_shr >= SW'(MIN_TABLE_SIZE))
             && (cnt_r < ns_shr);
    // An entry stays if its home is cyclically after the hole, up to its slot.
    keep      = ((hole_r < mod_rem) && (mod_rem <= i_r))
             || ((mod_rem <= i_r) && (i_r < hole_r))
             || ((i_r < hole_r) && (hole_r < mod_rem));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (sweep_r == '1) state_nxt = clr_res_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (op_r) inside
          OP_FIND, OP_ERASE:   state_nxt = S_PSTART;
          OP_INSERT, OP_UPDATE: state_nxt = S_RCALC;
          OP_CLEAR:            state_nxt = S_CLR;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_PSTART: state_nxt = S_PMOD;
      S_PMOD: begin
        if (mod_done) state_nxt = S_PRD;
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (!rd_r.used) begin
          state_nxt = S_DONE;
        end else if (rd_match) begin
          state_nxt = (op_r == OP_ERASE) ? S_ERD : S_DONE;
        end else begin
          state_nxt = k_last ? S_DONE : S_PRD;
        end
      end
      S_ERD: state_nxt = S_ECHK;
      S_ECHK: state_nxt = rd_r.used ? S_EMOD : S_EEND;
      S_EMOD: begin
        if (mod_done) state_nxt = S_ECMP;
      end
      S_ECMP: state_nxt = k_last ? S_EEND : S_ERD;
      S_EEND: state_nxt = S_RCALC;
      S_RCALC: state_nxt = S_RDEC;
      S_RDEC: begin
        if (grow) begin
          state_nxt = grow_fail ? S_DONE : S_RCLR;
        end else if (shrink_ok) begin
          state_nxt = S_RCLR;
        end else begin
          state_nxt = is_store ? S_PSTART : S_DONE;
        end
      end
      S_RCLR: begin
        if (ns_last) state_nxt = S_HRD;
      end
      S_HRD: state_nxt = S_HCHK;
      S_HCHK: begin
        if (rd_r.used) begin
          state_nxt = S_HMOD;
        end else if (i_last) begin
          state_nxt = is_store ? S_PSTART : S_DONE;
        end else begin
          state_nxt = S_HRD;
        end
      end
      S_HMOD: begin
        if (mod_done) state_nxt = S_HPRD;
      end
      S_HPRD: state_nxt = S_HPCHK;
      S_HPCHK: begin
        if (rd_r.used && !kh_last) begin
          state_nxt = S_HPRD;
        end else if (i_last) begin
          state_nxt = is_store ? S_PSTART : S_DONE;
        end else begin
          state_nxt = S_HRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    val_nxt        = val_r;
    size_nxt       = size_r;
    cnt_nxt        = cnt_r;
    bank_nxt       = bank_r;
    ns_nxt         = ns_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    hole_nxt       = hole_r;
    k_nxt          = k_r;
    ent_nxt        = ent_r;
    sweep_nxt      = sweep_r;
    clr_res_nxt    = clr_res_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    mem_we         = 1'b0;
    mem_waddr      = {bank_r, p_r};
    mem_wdata      = '0;
    mem_raddr      = {bank_r, p_r};
    mod_start      = 1'b0;
    mod_dvd        = hash_r;
    mod_dvs        = size_r;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == '1) begin
          size_nxt = SW'(MIN_TABLE_SIZE);
          cnt_nxt  = '0;
        end
      end
      S_IDLE: begin
        op_nxt   = in_tdata[2:0];
        key_nxt  = in_tdata[K0 +: KEY_BITS];
        hash_nxt = in_tdata[H0 +: HASH_BITS];
        val_nxt  = in_tdata[V0 +: VALUE_BITS];
      end
      S_DISP: begin
        res_status_nxt = STAT_OK;
        res_found_nxt  = '0;
        sweep_nxt      = '0;
        clr_res_nxt    = 1'b1;
      end
      S_PSTART: begin
        mod_start = 1'b1;
        k_nxt     = '0;
      end
      S_PMOD: begin
        if (mod_done) p_nxt = mod_rem;
      end
      S_PRD: mem_raddr = {bank_r, p_r};
      S_PCHK: begin
        if (!rd_r.used) begin
          if (is_store) begin
            mem_we         = 1'b1;
            mem_wdata      = '{used: 1'b1, key: key_r, value: val_r, hash: hash_r};
            cnt_nxt        = cnt_r + SW'(1);
            res_status_nxt = STAT_OK;
          end else begin
            res_status_nxt = STAT_DNE;
          end
        end else if (rd_match) begin
          case (op_r)
            OP_FIND:   res_found_nxt = rd_r.value;
            OP_INSERT: res_status_nxt = STAT_AE;
            OP_UPDATE: begin
              mem_we    = 1'b1;
              mem_wdata = '{used: 1'b1, key: key_r, value: val_r, hash: hash_r};
            end
            default: begin
              hole_nxt = p_r;
              i_nxt    = p_inc;
              k_nxt    = '0;
            end
          endcase
        end else if (k_last) begin
          res_status_nxt = is_store ? STAT_OOM : STAT_DNE;
        end else begin
          k_nxt = k_r + SW'(1);
          p_nxt = p_inc;
        end
      end
      S_ERD: mem_raddr = {bank_r, i_r};
      S_ECHK: begin
        ent_nxt   = rd_r;
        mod_start = rd_r.used;
        mod_dvd   = rd_r.hash;
      end
      S_ECMP: begin
        if (!keep) begin
          mem_we    = 1'b1;
          mem_waddr = {bank_r, hole_r};
          mem_wdata = ent_r;
          hole_nxt  = i_r;
        end
        i_nxt = i_inc;
        k_nxt = k_r + SW'(1);
      end
      S_EEND: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_r, hole_r};
        if (cnt_r != '0) cnt_nxt = cnt_r - SW'(1);
      end
      S_RDEC: begin
        i_nxt = '0;
        if (grow) begin
          if (grow_fail) begin
            res_status_nxt = is_store ? STAT_OOM : STAT_OK;
          end else begin
            ns_nxt = SW'(ns_grow);
          end
        end else begin
          ns_nxt = ns_shr;
        end
      end
      S_RCLR: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_r, i_r};
        i_nxt     = ns_last ? '0 : i_r + IW'(1);
      end
      S_HRD: mem_raddr = {bank_r, i_r};
      S_HCHK: begin
        if (rd_r.used) begin
          ent_nxt   = rd_r;
          mod_start = 1'b1;
          mod_dvd   = rd_r.hash;
          mod_dvs   = ns_r;
          k_nxt     = '0;
        end else if (i_last) begin
          bank_nxt = ~bank_r;
          size_nxt = ns_r;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_HMOD: begin
        mod_dvs = ns_r;
        if (mod_done) p_nxt = mod_rem;
      end
      S_HPRD: mem_raddr = {~bank_r, p_r};
      S_HPCHK: begin
        if (rd_r.used && !kh_last) begin
          k_nxt = k_r + SW'(1);
          p_nxt = ph_inc;
        end else begin
          if (!rd_r.used) begin
            mem_we    = 1'b1;
            mem_waddr = {~bank_r, p_r};
            mem_wdata = ent_r;
          end
          if (i_last) begin
            bank_nxt = ~bank_r;
            size_nxt = ns_r;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      clr_res_r   <= 1'b0;
      size_r      <= SW'(MIN_TABLE_SIZE);
      cnt_r       <= '0;
      bank_r      <= 1'b0;
      grow_r      <= GROW_RESET;
      shrink_r    <= SHRINK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      clr_res_r <= clr_res_nxt;
      size_r    <= size_nxt;
      cnt_r     <= cnt_nxt;
      bank_r    <= bank_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_GROW) grow_r <= cfg_wdata;
        if (cfg_index == CFG_SHRINK) shrink_r <= cfg_wdata;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    val_r        <= val_nxt;
    ns_r         <= ns_nxt;
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    hole_r       <= hole_nxt;
    k_r          <= k_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    gthr_r       <= gthr_c;
    sthr_r       <= sthr_c;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_entries_r <= cnt_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_entries_r, out_found_r, out_status_r});

  // The entry count can never exceed the live table size.
  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= size_r)
    else $error("entry count above table size");

  // The table never drops below its minimum size.
  a_size_min: assert property (@(posedge clk) disable iff (!rst_n)
    size_r >= SW'(MIN_TABLE_SIZE))
    else $error("table size below minimum");

  // A remainder only completes while the sequencer is waiting for one.
  a_mod_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_PMOD || state_r == S_EMOD || state_r == S_HMOD))
    else $error("remainder completed outside a wait state");

  // A new result only appears as the sequencer leaves its result state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the result state");

endmodule

@@ sim/tb_linear_probe_hash_map_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_map_unit
// Self-checking bench for the hash map unit. Every transaction is sent
// through a shadow map in the bench, which works out the status, the found
// value and the entry count. Each result is compared with the oldest of
// those predictions. Directed tests cover the corner cases; random traffic
// then runs under several load settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_map_unit;
  import lphm_pkg::*;

  localparam int CAP      = 1024;
  localparam int MIN_SIZE = 29;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 48;
  localparam int STALL_LIMIT = 200000;

  // Same bit order as out_tdata: status lowest, entries highest.
  typedef struct packed {
    logic [10:0] entries;
    logic [31:0] found_value;
    logic [1:0]  status;
  } map_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;  // op, key, key_hash, value, zero fill
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // status, found_value, entries, zero fill
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_GROW;
  logic [LOAD_BITS-1:0] cfg_wdata = '0;

  linear_probe_hash_map_unit dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the map.
  logic        sh_used [2*CAP];
  logic [31:0] sh_key  [2*CAP];
  logic [31:0] sh_val  [2*CAP];
  logic [31:0] sh_hash [2*CAP];
  int unsigned sh_size;
  int unsigned sh_count;
  int unsigned sh_bank;
  int unsigned sh_grow;
  int unsigned sh_shrink;

  map_reply_t  pending_replies[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned bank_base(int unsigned bank);
    return (bank & 1) * CAP;
  endfunction

  // Returns 1 when a grow would not fit in one bank.
  function automatic bit rebalance_table();
    int unsigned n, new_n, src, dst, h, k;
    longint unsigned hi, lo;
    n  = sh_size;
    hi = n / 1024;
    lo = n % 1024;
    if (sh_count >= hi * sh_grow + (lo * sh_grow) / 1024) begin
      new_n = 2 * n + 3;
      if (new_n > CAP) return 1'b1;
    end else begin
      if (sh_count >= hi * sh_shrink || n == MIN_SIZE) return 1'b0;
      if (n < 3) return 1'b0;
      new_n = (n - 3) / 2;
      if (new_n < MIN_SIZE || sh_count >= new_n) return 1'b0;
    end
    src = bank_base(sh_bank);
    dst = bank_base(sh_bank ^ 1);
    for (int unsigned i = 0; i < new_n; i++) sh_used[dst+i] = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (sh_used[src+i]) begin
        h = sh_hash[src+i] % new_n;
        for (k = 0; k < new_n && sh_used[dst+h]; k++) h = (h + 1) % new_n;
        if (!sh_used[dst+h]) begin
          sh_used[dst+h] = 1'b1;
          sh_key[dst+h]  = sh_key[src+i];
          sh_val[dst+h]  = sh_val[src+i];
          sh_hash[dst+h] = sh_hash[src+i];
        end
      end
    end
    sh_bank ^= 1;
    sh_size = new_n;
    return 1'b0;
  endfunction

  function automatic int find_slot(logic [31:0] key, logic [31:0] hash);
    int unsigned n, b, p;
    n = sh_size;
    b = bank_base(sh_bank);
    p = hash % n;
    for (int unsigned k = 0; k < n; k++) begin
      if (!sh_used[b+p]) return -1;
      if (sh_hash[b+p] == hash && sh_key[b+p] == key) return int'(p);
      p = (p + 1) % n;
    end
    return -1;
  endfunction

  function automatic logic [1:0] store_entry(logic [31:0] key, logic [31:0] hash,
                                             logic [31:0] value, bit overwrite);
    int unsigned n, b, p;
    if (rebalance_table()) return STAT_OOM;
    n = sh_size;
    b = bank_base(sh_bank);
    p = hash % n;
    for (int unsigned k = 0; k < n; k++) begin
      if (!sh_used[b+p]) begin
        sh_used[b+p] = 1'b1;
        sh_key[b+p]  = key;
        sh_val[b+p]  = value;
        sh_hash[b+p] = hash;
        sh_count++;
        return STAT_OK;
      end
      if (sh_hash[b+p] == hash && sh_key[b+p] == key) begin
        if (!overwrite) return STAT_AE;
        sh_val[b+p] = value;
        return STAT_OK;
      end
      p = (p + 1) % n;
    end
    return STAT_OOM;
  endfunction

  // Backward shift deletion: later members of the cluster move into the hole
  // unless their home lies cyclically between the hole and their own slot.
  function automatic logic [1:0] erase_entry(logic [31:0] key, logic [31:0] hash);
    int unsigned n, b, hole, i, home, k;
    int at;
    n  = sh_size;
    b  = bank_base(sh_bank);
    at = find_slot(key, hash);
    if (at < 0) return STAT_DNE;
    hole = at;
    i = (hole + 1) % n;
    for (k = 0; k < n && sh_used[b+i]; k++) begin
      home = sh_hash[b+i] % n;
      if (!((hole < home && home <= i) || (home <= i && i < hole) ||
            (i < hole && hole < home))) begin
        sh_key[b+hole]  = sh_key[b+i];
        sh_val[b+hole]  = sh_val[b+i];
        sh_hash[b+hole] = sh_hash[b+i];
        sh_used[b+hole] = 1'b1;
        hole = i;
      end
      i = (i + 1) % n;
    end
    sh_used[b+hole] = 1'b0;
    if (sh_count > 0) sh_count--;
    void'(rebalance_table());
    return STAT_OK;
  endfunction

  function automatic map_reply_t apply_map_op(logic [2:0] op, logic [31:0] key,
                                              logic [31:0] hash, logic [31:0] value);
    map_reply_t r;
    int at;
    r = '0;
    case (op)
      OP_FIND: begin
        at = find_slot(key, hash);
        if (at < 0) r.status = STAT_DNE;
        else r.found_value = sh_val[bank_base(sh_bank) + at];
      end
      OP_INSERT: r.status = store_entry(key, hash, value, 1'b0);
      OP_UPDATE: r.status = store_entry(key, hash, value, 1'b1);
      OP_ERASE:  r.status = erase_entry(key, hash);
      OP_CLEAR: begin
        for (int i = 0; i < 2*CAP; i++) sh_used[i] = 1'b0;
        sh_size  = MIN_SIZE;
        sh_count = 0;
      end
      default: ;
    endcase
    r.entries = sh_count[10:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so that back-to-back items never toggle it.
  task automatic send_map_op(logic [2:0] op, logic [31:0] key, logic [31:0] hash,
                             logic [31:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {5'd0, value, hash, key, op};
    in_tvalid <= 1'b1;
    pending_replies.push_back(apply_map_op(op, key, hash, value));
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    // Leave a quiet stretch before the next test starts.
    repeat (2 * 2 * CAP + 50) @(negedge clk);
  endtask

  task automatic write_load(logic idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[LOAD_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_GROW) sh_grow = value;
    else sh_shrink = value;
  endtask

  task automatic set_loads(int unsigned grow, int unsigned shrink);
    write_load(CFG_GROW, grow);
    write_load(CFG_SHRINK, shrink);
  endtask

  task automatic test_basic_ops();
    send_map_op(OP_FIND,   32'd5, 32'd5, 32'd0);
    send_map_op(OP_ERASE,  32'd5, 32'd5, 32'd0);
    send_map_op(OP_INSERT, 32'd0, 32'd0, 32'd0);
    send_map_op(OP_INSERT, '1, '1, '1);
    send_map_op(OP_INSERT, '1, '1, 32'h1234_5678);
    send_map_op(OP_UPDATE, '1, '1, 32'hA5A5_5A5A);
    send_map_op(OP_UPDATE, 32'd77, 32'd77, 32'h0BAD_F00D);
    send_map_op(OP_FIND,   '1, '1, 32'd0);
    send_map_op(OP_FIND,   32'd0, 32'd0, 32'd0);
    // Same hash, different keys: a cluster that the erase has to close up.
    send_map_op(OP_INSERT, 32'd100, 32'd3, 32'd1);
    send_map_op(OP_INSERT, 32'd101, 32'd3, 32'd2);
    send_map_op(OP_INSERT, 32'd102, 32'd3, 32'd3);
    send_map_op(OP_FIND,   32'd101, 32'd4, 32'd0);
    send_map_op(OP_ERASE,  32'd100, 32'd3, 32'd0);
    send_map_op(OP_FIND,   32'd102, 32'd3, 32'd0);
    send_map_op(OP_ERASE,  32'd0, 32'd0, 32'd0);
    send_map_op(3'd5, '1, '1, '1);
    send_map_op(3'd6, 32'd0, 32'd0, 32'd0);
    send_map_op(3'd7, 32'd1, 32'd1, 32'd1);
    send_map_op(OP_CLEAR,  32'd0, 32'd0, 32'd0);
    send_map_op(OP_FIND,   32'd101, 32'd3, 32'd0);
    drain_replies();
  endtask

  // With a grow setting of 1 every insert grows the table, so the sixth
  // one no longer fits and reports out of memory.
  task automatic test_grow_limit();
    set_loads(1, 0);
    for (int i = 0; i < 7; i++) send_map_op(OP_INSERT, i, i * 7, i + 1);
    send_map_op(OP_UPDATE, 32'd2, 32'd14, 32'd99);
    send_map_op(OP_ERASE,  32'd3, 32'd21, 32'd0);
    send_map_op(OP_FIND,   32'd4, 32'd28, 32'd0);
    send_map_op(OP_CLEAR,  32'd0, 32'd0, 32'd0);
    drain_replies();
  endtask

  task automatic test_random_traffic(int items, int unsigned grow, int unsigned shrink);
    logic [2:0]  op;
    logic [31:0] key, hash;
    int pick;
    set_loads(grow, shrink);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) op = OP_FIND;
      else if (pick < 52) op = OP_INSERT;
      else if (pick < 67) op = OP_UPDATE;
      else if (pick < 95) op = OP_ERASE;
      else if (pick < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      key  = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 47);
      pick = $urandom_range(0, 9);
      // Mostly a fixed hash per key, some forced clustering, some noise.
      if (pick < 7) hash = key * 32'h9E37_79B1;
      else if (pick < 9) hash = key & 32'd7;
      else hash = $urandom();
      send_map_op(op, key, hash, $urandom());
    end
    drain_replies();
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    map_reply_t want, got;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[44:0];
      if (pending_replies.size() == 0) begin
        $display("%0t: result with no transaction outstanding: %h", $realtime, got);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, got.status);
          fail_count++;
        end
        if (got.found_value !== want.found_value) begin
          $display("%0t: found_value expected %h actual %h", $realtime,
                   want.found_value, got.found_value);
          fail_count++;
        end
        if (got.entries !== want.entries) begin
          $display("%0t: entries expected %0d actual %0d", $realtime,
                   want.entries, got.entries);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 2*CAP; i++) sh_used[i] = 1'b0;
    sh_size   = MIN_SIZE;
    sh_count  = 0;
    sh_bank   = 0;
    sh_grow   = 768;
    sh_shrink = 256;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 37;
    recv_stall_pct = 49;
    test_basic_ops();
    test_grow_limit();
    test_random_traffic(330, 768, 256);
    send_idle_pct  = 49;
    recv_stall_pct = 37;
    test_random_traffic(330, 1023, 1023);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(340, 512, 512);

    if (pending_replies.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lphm_pkg.sv
src/lphm_mod.sv
src/linear_probe_hash_map_unit.sv
sim/tb_linear_probe_hash_map_unit.sv
